>>> rtl/ifa_pkg.sv
package ifa_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_CALC,
    ST_SIZE,
    ST_LIMIT,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  typedef enum logic [2:0] {
    SEG_LEAD,
    SEG_SIGN,
    SEG_PFX0,
    SEG_PFXX,
    SEG_ZERO,
    SEG_PAD,
    SEG_DIG,
    SEG_TRAIL
  } seg_t;

  localparam logic [1:0] RADIX_OCT = 2'd0;
  localparam logic [1:0] RADIX_DEC = 2'd1;

  localparam int FLAG_PLUS  = 0;
  localparam int FLAG_SPACE = 1;
  localparam int FLAG_ALT   = 2;
  localparam int FLAG_ZERO  = 3;
  localparam int FLAG_LEFT  = 4;
  localparam int FLAG_UPPER = 5;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;

  typedef struct packed {
    logic clear;
    logic shift;
    logic bit_in;
    logic is_oct;
    logic is_dec;
  } chain_ctl_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UA : CH_LA;
    if (d < 4'd10) digit_char = CH_ZERO + {4'b0, d};
    else digit_char = base + {4'b0, d} - 8'd10;
  endfunction

endpackage

>>> rtl/integer_to_ascii_formatter_unit.sv
// channel   | signals                                          | handshake
// request   | magnitude .. space_left                          | start & !busy
// character | out_char, last, empty_res, written_count         | strobe, one cycle
//
// a transaction runs a bit-serial digit conversion of all VALUE_BITS bits, a
// leading-digit scan and the setup states CALC, SIZE and LIMIT, then forms one
// output character per cycle, but for the segment boundaries, seven at most, where
// none is formed; each character shows on the ports in the cycle after it is formed.
// rst is synchronous and returns the unit to idle with no strobe pending.
// the receiver cannot stall; busy falls in the cycle that shows the last character.
module integer_to_ascii_formatter_unit #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_OUT    = 64,
  parameter int MAX_DIGITS = 22
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [63:0]       magnitude,
  input  logic              signed_conv,
  input  logic              is_negative,
  input  logic [1:0]        radix_sel,
  input  logic [5:0]        flag_bits,
  input  logic signed [6:0] precision,
  input  logic              precision_zero,
  input  logic signed [6:0] min_width,
  input  logic [6:0]        space_left,
  output logic              strobe,
  output logic [7:0]        out_char,
  output logic              last,
  output logic              empty_res,
  output logic [6:0]        written_count
);
  import ifa_pkg::*;

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int NW    = $clog2(MAX_DIGITS + 1);
  localparam int BW    = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  state_t state, state_next;
  seg_t   seg, seg_next;

  logic [VALUE_BITS-1:0] val_sr;
  logic [BW-1:0]         bit_cnt;
  logic                  nz;
  logic                  r_sconv, r_neg, r_pz;
  logic [1:0]            r_radix;
  logic [5:0]            r_flags;
  logic signed [6:0]     r_prec, r_fw;
  logic [6:0]            lim;
  logic [NW-1:0]         n;
  logic [IDX_W-1:0]      rd_idx;
  logic [6:0]            prec_eff;
  logic [8:0]            fwp;
  logic [1:0]            pfx;
  logic                  has_sign;
  logic [7:0]            sign_char;
  logic                  alt_zero, blank;
  logic [6:0]            lead, zero_cnt, zpad, trail;
  logic [7:0]            total;
  logic [6:0]            total_out;
  logic [6:0]            seg_cnt, seg_len_next, out_cnt;

  logic       accept, emit, emit_last, scan_hit, conv_done;
  logic       is_oct, is_dec, is_hex;
  logic [3:0] rd_digit;
  logic       ovf;
  logic [7:0] char_c;
  logic [6:0] padn_c, total_out_c;
  chain_ctl_t chain_ctl;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign is_oct = (r_radix == RADIX_OCT);
  assign is_dec = (r_radix == RADIX_DEC);
  assign is_hex = !is_oct && !is_dec;

  ifa_digit_chain #(.MAX_DIGITS(MAX_DIGITS), .IDX_W(IDX_W)) u_chain (
    .clk      (clk),
    .ctl      (chain_ctl),
    .rd_idx   (rd_idx),
    .rd_digit (rd_digit),
    .ovf      (ovf)
  );

  always_comb begin
    chain_ctl.clear  = accept;
    chain_ctl.shift  = (state == ST_CONV);
    chain_ctl.bit_in = val_sr[VALUE_BITS-1];
    chain_ctl.is_oct = is_oct;
    chain_ctl.is_dec = is_dec;
    conv_done   = (bit_cnt == '0);
    scan_hit    = ovf || (rd_digit != 4'd0) || (rd_idx == '0);
    emit        = (state == ST_EMIT) && (seg_cnt != 7'd0);
    emit_last   = emit && (out_cnt == total_out - 7'd1);
    padn_c      = (alt_zero || fwp[8] || fwp == 9'd0) ? 7'd0 : fwp[6:0];
    total_out_c = (total > {1'b0, lim}) ? lim : total[6:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) begin
                  if (precision_zero && (min_width[6] || min_width == 7'sd0))
                    state_next = ST_EMPTY;
                  else
                    state_next = ST_CONV;
                end
      ST_CONV:  if (conv_done) state_next = ST_SCAN;
      ST_SCAN:  if (scan_hit) state_next = ST_CALC;
      ST_CALC:  state_next = ST_SIZE;
      ST_SIZE:  state_next = ST_LIMIT;
      ST_LIMIT: state_next = (total_out_c == 7'd0) ? ST_EMPTY : ST_EMIT;
      ST_EMIT:  if (emit_last) state_next = ST_IDLE;
      ST_EMPTY: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (seg)
      SEG_LEAD:  seg_next = SEG_SIGN;
      SEG_SIGN:  seg_next = SEG_PFX0;
      SEG_PFX0:  seg_next = SEG_PFXX;
      SEG_PFXX:  seg_next = SEG_ZERO;
      SEG_ZERO:  seg_next = SEG_PAD;
      SEG_PAD:   seg_next = SEG_DIG;
      SEG_DIG:   seg_next = SEG_TRAIL;
      SEG_TRAIL: seg_next = SEG_TRAIL;
      default:   seg_next = SEG_TRAIL;
    endcase
    unique case (seg_next)
      SEG_LEAD:  seg_len_next = lead;
      SEG_SIGN:  seg_len_next = {6'd0, has_sign};
      SEG_PFX0:  seg_len_next = {6'd0, pfx != 2'd0};
      SEG_PFXX:  seg_len_next = {6'd0, pfx == 2'd2};
      SEG_ZERO:  seg_len_next = zero_cnt;
      SEG_PAD:   seg_len_next = zpad;
      SEG_DIG:   seg_len_next = 7'(n);
      SEG_TRAIL: seg_len_next = trail;
      default:   seg_len_next = 7'd0;
    endcase
    unique case (seg)
      SEG_SIGN:  char_c = sign_char;
      SEG_PFX0:  char_c = CH_ZERO;
      SEG_PFXX:  char_c = r_flags[FLAG_UPPER] ? CH_UX : CH_LX;
      SEG_ZERO:  char_c = CH_ZERO;
      SEG_PAD:   char_c = CH_ZERO;
      SEG_DIG:   char_c = blank ? CH_SPACE : digit_char(rd_digit, r_flags[FLAG_UPPER]);
      default:   char_c = CH_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit || (state == ST_EMPTY);
    end
  end

  always_ff @(posedge clk) begin
    out_char      <= emit ? char_c : 8'd0;
    last          <= emit_last || (state == ST_EMPTY);
    empty_res     <= (state == ST_EMPTY);
    written_count <= emit_last ? out_cnt + 7'd1 : 7'd0;

    unique case (state)
      ST_IDLE: if (accept) begin
        val_sr   <= magnitude[VALUE_BITS-1:0];
        bit_cnt  <= BW'(VALUE_BITS - 1);
        nz       <= 1'b0;
        r_sconv  <= signed_conv;
        r_neg    <= is_negative;
        r_radix  <= radix_sel;
        r_flags  <= flag_bits;
        r_prec   <= precision;
        r_pz     <= precision_zero;
        r_fw     <= min_width;
        lim      <= (space_left > 7'(MAX_OUT)) ? 7'(MAX_OUT) : space_left;
      end
      ST_CONV: begin
        nz      <= nz | val_sr[VALUE_BITS-1];
        val_sr  <= val_sr << 1;
        bit_cnt <= bit_cnt - BW'(1);
        rd_idx  <= IDX_W'(MAX_DIGITS - 1);
      end
      ST_SCAN: begin
        if (ovf) n <= NW'(MAX_DIGITS);
        else if (scan_hit) n <= NW'(rd_idx) + NW'(1);
        else rd_idx <= rd_idx - IDX_W'(1);
      end
      ST_CALC: begin
        alt_zero  <= !nz && r_flags[FLAG_ALT];
        blank     <= !nz && r_pz && !r_flags[FLAG_ALT];
        sign_char <= r_neg ? CH_MINUS : (r_flags[FLAG_PLUS] ? CH_PLUS : CH_SPACE);
        if (!nz && r_flags[FLAG_ALT]) begin
          has_sign <= 1'b0;
          pfx      <= 2'd0;
          prec_eff <= 7'd1;
          fwp      <= 9'd0;
        end else begin
          has_sign <= r_sconv && (r_neg || r_flags[FLAG_PLUS] || r_flags[FLAG_SPACE]);
          pfx      <= (r_flags[FLAG_ALT] && !is_dec) ? (is_hex ? 2'd2 : 2'd1) : 2'd0;
          prec_eff <= (r_prec[6] || r_prec < $signed({1'b0, 6'(n)})) ? 7'(n) : r_prec;
          fwp      <= {{2{r_fw[6]}}, r_fw}
                      - {8'd0, r_sconv && (r_neg || r_flags[FLAG_PLUS] || r_flags[FLAG_SPACE])}
                      - ((r_prec[6] || r_prec < $signed({1'b0, 6'(n)})) ? 9'(n) : {2'b0, r_prec})
                      - ((r_flags[FLAG_ALT] && !is_dec) ? (is_hex ? 9'd2 : 9'd1) : 9'd0);
        end
      end
      ST_SIZE: begin
        lead     <= (!r_flags[FLAG_LEFT] && !r_flags[FLAG_ZERO]) ? padn_c : 7'd0;
        zpad     <= (!r_flags[FLAG_LEFT] && r_flags[FLAG_ZERO]) ? padn_c : 7'd0;
        trail    <= r_flags[FLAG_LEFT] ? padn_c : 7'd0;
        zero_cnt <= alt_zero ? 7'd0 : prec_eff - 7'(n);
        total    <= 8'(has_sign) + 8'(pfx) + {1'b0, prec_eff} + {1'b0, padn_c};
        if (alt_zero) n <= NW'(1);
      end
      ST_LIMIT: begin
        total_out <= total_out_c;
        seg       <= SEG_LEAD;
        seg_cnt   <= lead;
        out_cnt   <= 7'd0;
        rd_idx    <= IDX_W'(n - NW'(1));
      end
      ST_EMIT: begin
        if (seg_cnt == 7'd0) begin
          seg     <= seg_next;
          seg_cnt <= seg_len_next;
        end else begin
          seg_cnt <= seg_cnt - 7'd1;
          out_cnt <= out_cnt + 7'd1;
          if (seg == SEG_DIG && rd_idx != '0) rd_idx <= rd_idx - IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy) else $error("last character shown while still busy");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy) else $error("transaction ended without last");

  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    empty_res |-> strobe && last && written_count == 7'd0) else $error("bad empty result");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted transaction did not start");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> written_count <= 7'(MAX_OUT)) else $error("count beyond limit");

endmodule

>>> rtl/ifa_digit_chain.sv
module ifa_digit_chain #(
  parameter int MAX_DIGITS = 22,
  parameter int IDX_W = $clog2(MAX_DIGITS)
) (
  input  logic                clk,
  input  ifa_pkg::chain_ctl_t ctl,
  input  logic [IDX_W-1:0]    rd_idx,
  output logic [3:0]          rd_digit,
  output logic                ovf
);
  import ifa_pkg::*;

  logic [3:0]        dig      [MAX_DIGITS];
  logic [3:0]        dig_next [MAX_DIGITS];
  logic [3:0]        corr     [MAX_DIGITS];
  logic [MAX_DIGITS:0] carry;

  // one bit enters per cycle while shift is set, msb first; decimal digits get the add-3 step
  always_comb begin
    carry[0] = ctl.bit_in;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      corr[i] = (ctl.is_dec && dig[i] >= 4'd5) ? dig[i] + 4'd3 : dig[i];
      carry[i+1] = ctl.is_oct ? corr[i][2] : corr[i][3];
      dig_next[i] = ctl.is_oct ? {1'b0, corr[i][1:0], carry[i]} : {corr[i][2:0], carry[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      for (int i = 0; i < MAX_DIGITS; i++) dig[i] <= 4'd0;
      ovf <= 1'b0;
    end else if (ctl.shift) begin
      for (int i = 0; i < MAX_DIGITS; i++) dig[i] <= dig_next[i];
      ovf <= ovf | carry[MAX_DIGITS];
    end
  end

  assign rd_digit = dig[rd_idx];

endmodule
